>>> design/ssi_pkg.sv
`timescale 1ns / 1ps

package ssi_pkg;

  // Coordinate width; every internal width follows from it
  localparam int CW   = 32;
  localparam int DW   = CW + 1;          // point differences
  localparam int PW   = 2 * DW;          // cross products
  localparam int SW   = PW + 1;          // den, tn, un (signed)
  localparam int MW   = PW;              // |den| and in-range tn
  localparam int LW   = (MW + 1) / 2;    // low split of den / tn
  localparam int HW   = MW - LW;         // high split of den / tn
  localparam int PPW  = DW + LW + 1;     // partial product width
  localparam int NXW  = DW + MW + 2;     // crossing numerator width

  typedef struct packed {
    logic signed [CW-1:0] first_start_x;
    logic signed [CW-1:0] first_start_y;
    logic signed [CW-1:0] first_end_x;
    logic signed [CW-1:0] first_end_y;
    logic signed [CW-1:0] second_start_x;
    logic signed [CW-1:0] second_start_y;
    logic signed [CW-1:0] second_end_x;
    logic signed [CW-1:0] second_end_y;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } res_t;

  // Start point and direction of the first segment
  typedef struct packed {
    logic signed [DW-1:0] asx;
    logic signed [DW-1:0] asy;
    logic signed [DW-1:0] dax;
    logic signed [DW-1:0] day;
  } geo_t;

  // Front end result: hit decision, positive den and matching tn
  typedef struct packed {
    logic          hit;
    logic [MW-1:0] den;
    logic [MW-1:0] tn;
    geo_t          geo;
  } front_t;

  // One step of the shared-divisor restoring divider
  typedef struct packed {
    logic           hit;
    logic           neg_x;
    logic           neg_y;
    logic [NXW-1:0] den_sh;
    logic [NXW-1:0] rem_x;
    logic [NXW-1:0] rem_y;
    logic [CW-1:0]  q_x;
    logic [CW-1:0]  q_y;
  } div_t;

  function automatic logic signed [DW-1:0] ext_coord(input logic [CW-1:0] a);
    ext_coord = $signed({a[CW-1], a});
  endfunction

endpackage

>>> design/segment_segment_intersection_unit.sv
`timescale 1ns / 1ps

// Segment crossing test in signed fixed point. Takes one segment pair per
// cycle and returns hit plus the crossing point on the first segment, rounded
// toward zero, or zero without a hit (parallel, collinear or out of range).
// The pipeline has four stages of cross products and range test, three of
// numerator products, one restoring divider stage per quotient bit and the
// output register. Throughput is one pair per cycle; a stall on the result
// side holds the whole pipeline.
module segment_segment_intersection_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ssi_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ssi_pkg::res_t  out_res_o
);

  logic en;
  logic front_valid, numer_valid;
  ssi_pkg::front_t front;
  logic [ssi_pkg::CW:0] div_valid;
  ssi_pkg::div_t div_chain [ssi_pkg::CW+1];
  logic out_valid_q;
  ssi_pkg::res_t res_d, res_q;

  // Hold everything while a finished result is not taken
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  ssi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .valid_o (front_valid),
    .front_o (front)
  );

  ssi_numer u_numer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .front_i (front),
    .valid_o (numer_valid),
    .div_o   (div_chain[0])
  );

  assign div_valid[0] = numer_valid;

  // Divider: one stage per quotient bit, most significant first
  for (genvar g = 0; g < ssi_pkg::CW; g++) begin : g_div
    ssi_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[g]),
      .div_i   (div_chain[g]),
      .valid_o (div_valid[g+1]),
      .div_o   (div_chain[g+1])
    );
  end

  // Apply sign, zero the point without a hit
  always_comb begin
    res_d.hit     = div_chain[ssi_pkg::CW].hit;
    res_d.cross_x = '0;
    res_d.cross_y = '0;
    if (div_chain[ssi_pkg::CW].hit) begin
      res_d.cross_x = div_chain[ssi_pkg::CW].neg_x ? -$signed(div_chain[ssi_pkg::CW].q_x)
                                                   : $signed(div_chain[ssi_pkg::CW].q_x);
      res_d.cross_y = div_chain[ssi_pkg::CW].neg_y ? -$signed(div_chain[ssi_pkg::CW].q_y)
                                                   : $signed(div_chain[ssi_pkg::CW].q_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid[ssi_pkg::CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

>>> design/ssi_front.sv
`timescale 1ns / 1ps

// Differences, cross products, den/tn/un and the range test: four stages
module ssi_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ssi_pkg::req_t    req_i,
  output logic             valid_o,
  output ssi_pkg::front_t  front_o
);

  logic v1_q, v2_q, v3_q, v4_q;

  ssi_pkg::geo_t geo1_q, geo2_q, geo3_q;
  logic signed [ssi_pkg::DW-1:0] dbx_q, dby_q, ox_q, oy_q;
  logic signed [ssi_pkg::PW-1:0] p_den0_q, p_den1_q, p_tn0_q, p_tn1_q, p_un0_q, p_un1_q;
  logic signed [ssi_pkg::SW-1:0] den_q, tn_q, un_q;
  ssi_pkg::front_t front_d, front_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 1: differences
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo1_q.asx <= ssi_pkg::ext_coord(req_i.first_start_x);
      geo1_q.asy <= ssi_pkg::ext_coord(req_i.first_start_y);
      geo1_q.dax <= ssi_pkg::ext_coord(req_i.first_end_x)
                  - ssi_pkg::ext_coord(req_i.first_start_x);
      geo1_q.day <= ssi_pkg::ext_coord(req_i.first_end_y)
                  - ssi_pkg::ext_coord(req_i.first_start_y);
      dbx_q <= ssi_pkg::ext_coord(req_i.second_end_x)
             - ssi_pkg::ext_coord(req_i.second_start_x);
      dby_q <= ssi_pkg::ext_coord(req_i.second_end_y)
             - ssi_pkg::ext_coord(req_i.second_start_y);
      ox_q  <= ssi_pkg::ext_coord(req_i.first_start_x)
             - ssi_pkg::ext_coord(req_i.second_start_x);
      oy_q  <= ssi_pkg::ext_coord(req_i.first_start_y)
             - ssi_pkg::ext_coord(req_i.second_start_y);
    end
  end

  // Stage 2: six cross products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo2_q   <= geo1_q;
      p_den0_q <= dby_q * geo1_q.dax;
      p_den1_q <= dbx_q * geo1_q.day;
      p_tn0_q  <= dbx_q * oy_q;
      p_tn1_q  <= dby_q * ox_q;
      p_un0_q  <= geo1_q.dax * oy_q;
      p_un1_q  <= geo1_q.day * ox_q;
    end
  end

  // Stage 3: den, tn, un
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo3_q <= geo2_q;
      den_q  <= $signed({p_den0_q[ssi_pkg::PW-1], p_den0_q})
              - $signed({p_den1_q[ssi_pkg::PW-1], p_den1_q});
      tn_q   <= $signed({p_tn0_q[ssi_pkg::PW-1], p_tn0_q})
              - $signed({p_tn1_q[ssi_pkg::PW-1], p_tn1_q});
      un_q   <= $signed({p_un0_q[ssi_pkg::PW-1], p_un0_q})
              - $signed({p_un1_q[ssi_pkg::PW-1], p_un1_q});
    end
  end

  // Stage 4: make den positive and test both parameters against [0, den]
  always_comb begin
    logic signed [ssi_pkg::SW-1:0] dn, tnn, unn;
    dn  = den_q[ssi_pkg::SW-1] ? -den_q : den_q;
    tnn = den_q[ssi_pkg::SW-1] ? -tn_q  : tn_q;
    unn = den_q[ssi_pkg::SW-1] ? -un_q  : un_q;
    front_d.hit = (den_q != '0) && !tnn[ssi_pkg::SW-1] && (tnn <= dn)
                  && !unn[ssi_pkg::SW-1] && (unn <= dn);
    front_d.den = dn[ssi_pkg::MW-1:0];
    front_d.tn  = tnn[ssi_pkg::MW-1:0];
    front_d.geo = geo3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign valid_o = v4_q;
  assign front_o = front_q;

endmodule

>>> design/ssi_numer.sv
`timescale 1ns / 1ps

// Crossing numerators asx*den + tn*dax (and y), split into partial products
module ssi_numer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ssi_pkg::front_t  front_i,
  output logic             valid_o,
  output ssi_pkg::div_t    div_o
);

  logic va_q, vb_q, vc_q;
  logic hit_a_q, hit_b_q;
  logic [ssi_pkg::MW-1:0] den_a_q, den_b_q;
  logic signed [ssi_pkg::LW:0] den_lo, tn_lo;
  logic signed [ssi_pkg::HW:0] den_hi, tn_hi;
  logic signed [ssi_pkg::PPW-1:0] pxl_q, pxh_q, ptxl_q, ptxh_q;
  logic signed [ssi_pkg::PPW-1:0] pyl_q, pyh_q, ptyl_q, ptyh_q;
  logic signed [ssi_pkg::NXW-1:0] nx_q, ny_q;
  ssi_pkg::div_t div_d, div_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Split den and tn into positive low and high halves
  assign den_lo = $signed({1'b0, front_i.den[ssi_pkg::LW-1:0]});
  assign den_hi = $signed({1'b0, front_i.den[ssi_pkg::MW-1:ssi_pkg::LW]});
  assign tn_lo  = $signed({1'b0, front_i.tn[ssi_pkg::LW-1:0]});
  assign tn_hi  = $signed({1'b0, front_i.tn[ssi_pkg::MW-1:ssi_pkg::LW]});

  // Stage A: partial products on the low and high halves of den and tn
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_a_q <= front_i.hit;
      den_a_q <= front_i.den;
      pxl_q   <= front_i.geo.asx * den_lo;
      pxh_q   <= front_i.geo.asx * den_hi;
      ptxl_q  <= front_i.geo.dax * tn_lo;
      ptxh_q  <= front_i.geo.dax * tn_hi;
      pyl_q   <= front_i.geo.asy * den_lo;
      pyh_q   <= front_i.geo.asy * den_hi;
      ptyl_q  <= front_i.geo.day * tn_lo;
      ptyh_q  <= front_i.geo.day * tn_hi;
    end
  end

  // Stage B: sum partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_b_q <= hit_a_q;
      den_b_q <= den_a_q;
      nx_q <= ssi_pkg::NXW'(pxl_q) + (ssi_pkg::NXW'(pxh_q) <<< ssi_pkg::LW)
            + ssi_pkg::NXW'(ptxl_q) + (ssi_pkg::NXW'(ptxh_q) <<< ssi_pkg::LW);
      ny_q <= ssi_pkg::NXW'(pyl_q) + (ssi_pkg::NXW'(pyh_q) <<< ssi_pkg::LW)
            + ssi_pkg::NXW'(ptyl_q) + (ssi_pkg::NXW'(ptyh_q) <<< ssi_pkg::LW);
    end
  end

  // Stage C: split sign and magnitude, align divisor to the top quotient bit
  always_comb begin
    div_d.hit    = hit_b_q;
    div_d.neg_x  = nx_q[ssi_pkg::NXW-1];
    div_d.neg_y  = ny_q[ssi_pkg::NXW-1];
    div_d.rem_x  = nx_q[ssi_pkg::NXW-1] ? -nx_q : nx_q;
    div_d.rem_y  = ny_q[ssi_pkg::NXW-1] ? -ny_q : ny_q;
    div_d.den_sh = ssi_pkg::NXW'(den_b_q) << (ssi_pkg::CW - 1);
    div_d.q_x    = '0;
    div_d.q_y    = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = vc_q;
  assign div_o   = div_q;

endmodule

>>> design/ssi_div_stage.sv
`timescale 1ns / 1ps

// One restoring step: one quotient bit for x and for y
module ssi_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  ssi_pkg::div_t  div_i,
  output logic           valid_o,
  output ssi_pkg::div_t  div_o
);

  logic valid_q;
  ssi_pkg::div_t div_d, div_q;

  // Subtract the aligned divisor where it fits, then shift it down
  always_comb begin
    logic take_x, take_y;
    take_x = div_i.rem_x >= div_i.den_sh;
    take_y = div_i.rem_y >= div_i.den_sh;
    div_d        = div_i;
    div_d.rem_x  = take_x ? div_i.rem_x - div_i.den_sh : div_i.rem_x;
    div_d.rem_y  = take_y ? div_i.rem_y - div_i.den_sh : div_i.rem_y;
    div_d.q_x    = {div_i.q_x[ssi_pkg::CW-2:0], take_x};
    div_d.q_y    = {div_i.q_y[ssi_pkg::CW-2:0], take_y};
    div_d.den_sh = div_i.den_sh >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int LATENCY = ssi_pkg::CW + 8;
  localparam int N_RANDOM = 1900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  ssi_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  ssi_pkg::res_t out_res_o;

  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  ssi_pkg::res_t crossing_queue[$];

  segment_segment_intersection_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_res_o(out_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Exact predictor on wide signed integers
  function automatic ssi_pkg::res_t predict_crossing(ssi_pkg::req_t r);
    logic signed [255:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
    logic signed [255:0] dax, day, dbx, dby, ox, oy, den, tn, un, nx, ny, qx, qy;
    ssi_pkg::res_t res;
    asx = r.first_start_x;  asy = r.first_start_y;
    aex = r.first_end_x;    aey = r.first_end_y;
    bsx = r.second_start_x; bsy = r.second_start_y;
    bex = r.second_end_x;   bey = r.second_end_y;
    dax = aex - asx; day = aey - asy;
    dbx = bex - bsx; dby = bey - bsy;
    ox = asx - bsx;  oy = asy - bsy;
    den = dby * dax - dbx * day;
    tn = dbx * oy - dby * ox;
    un = dax * oy - day * ox;
    res = '0;
    if (den == 0) return res;
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
      nx = asx * den + tn * dax;
      ny = asy * den + tn * day;
      // SV division truncates toward zero
      qx = nx / den;
      qy = ny / den;
      res.hit = 1'b1;
      res.cross_x = qx[ssi_pkg::CW-1:0];
      res.cross_y = qy[ssi_pkg::CW-1:0];
    end
    return res;
  endfunction

  // Receiver: random stall and checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (crossing_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_res_o);
          error_count++;
        end else begin
          ssi_pkg::res_t want;
          want = crossing_queue.pop_front();
          if (want.hit !== out_res_o.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, out_res_o.hit);
            error_count++;
          end
          if (want.cross_x !== out_res_o.cross_x) begin
            $display("%0t: cross_x expected %h actual %h", $time, want.cross_x,
                     out_res_o.cross_x);
            error_count++;
          end
          if (want.cross_y !== out_res_o.cross_y) begin
            $display("%0t: cross_y expected %h actual %h", $time, want.cross_y,
                     out_res_o.cross_y);
            error_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Send one request, idling at random first
  task automatic send_request(ssi_pkg::req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    crossing_queue.push_back(predict_crossing(r));
  endtask

  function automatic logic [ssi_pkg::CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(64)) - 32;                 // tiny grid
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return $signed(($urandom_range(40) - 20)) <<< 16;  // whole units
    endcase
  endfunction

  // Random pair: mostly crossing-prone shapes, sometimes degenerate
  function automatic ssi_pkg::req_t rand_request();
    ssi_pkg::req_t r;
    int mode;
    mode = $urandom_range(3);
    r.first_start_x  = rand_coord(mode); r.first_start_y  = rand_coord(mode);
    r.first_end_x    = rand_coord(mode); r.first_end_y    = rand_coord(mode);
    r.second_start_x = rand_coord(mode); r.second_start_y = rand_coord(mode);
    r.second_end_x   = rand_coord(mode); r.second_end_y   = rand_coord(mode);
    case ($urandom_range(9))
      0: begin  // zero-length second segment
        r.second_end_x = r.second_start_x; r.second_end_y = r.second_start_y;
      end
      1: begin  // parallel: same direction shifted
        r.second_end_x = r.second_start_x + (r.first_end_x - r.first_start_x);
        r.second_end_y = r.second_start_y + (r.first_end_y - r.first_start_y);
      end
      2: begin  // share an endpoint
        r.second_start_x = r.first_end_x; r.second_start_y = r.first_end_y;
      end
      3: begin  // second is the other diagonal of first's box
        r.second_start_x = r.first_start_x; r.second_start_y = r.first_end_y;
        r.second_end_x = r.first_end_x;     r.second_end_y = r.first_start_y;
      end
      default: ;
    endcase
    return r;
  endfunction

  typedef struct {
    ssi_pkg::req_t r;
    logic known;
    ssi_pkg::res_t want;
  } vector_t;

  localparam logic [ssi_pkg::CW-1:0] MAXC = {1'b0, {(ssi_pkg::CW-1){1'b1}}};
  localparam logic [ssi_pkg::CW-1:0] MINC = {1'b1, {(ssi_pkg::CW-1){1'b0}}};
  localparam logic [ssi_pkg::CW-1:0] ONE = 32'h0001_0000;
  localparam logic [ssi_pkg::CW-1:0] TWO = 32'h0002_0000;

  vector_t directed[$];

  initial begin
    vector_t v;
    // Plain X crossing at (1,1)
    v.r = '{0, 0, TWO, TWO, 0, TWO, TWO, 0}; v.known = 1; v.want = '{1'b1, ONE, ONE};
    directed.push_back(v);
    // Parallel segments
    v.r = '{0, 0, TWO, 0, 0, ONE, TWO, ONE}; v.known = 1; v.want = '0;
    directed.push_back(v);
    // Collinear overlapping
    v.r = '{0, 0, TWO, 0, ONE, 0, 32'h0003_0000, 0}; v.known = 1; v.want = '0;
    directed.push_back(v);
    // Zero-length segment on the other
    v.r = '{0, 0, TWO, 0, ONE, 0, ONE, 0}; v.known = 1; v.want = '0;
    directed.push_back(v);
    // Touching at an endpoint, L shape
    v.r = '{0, 0, TWO, 0, TWO, 0, TWO, TWO}; v.known = 1; v.want = '{1'b1, TWO, 0};
    directed.push_back(v);
    // Both at start points
    v.r = '{0, 0, TWO, 0, 0, 0, 0, TWO}; v.known = 1; v.want = '{1'b1, 0, 0};
    directed.push_back(v);
    // Out of range: lines cross past the end
    v.r = '{0, 0, ONE, 0, TWO, ONE, TWO, 32'hffff_0000}; v.known = 1; v.want = '0;
    directed.push_back(v);
    // Extremes of the coordinate range
    v.r = '{MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC}; v.known = 0;
    directed.push_back(v);
    v.r = '{MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC}; v.known = 0;
    directed.push_back(v);
    v.r = '{MINC, 0, MAXC, 0, 0, MINC, 0, MAXC}; v.known = 1; v.want = '{1'b1, 0, 0};
    directed.push_back(v);
    v.r = '{'1, '1, '1, '1, '1, '1, '1, '1}; v.known = 1; v.want = '0;
    directed.push_back(v);
    // Small raw coordinates: a negative result and rounding toward zero
    v.r = '{0, 0, 32'hffff_fffd, 3, 32'hffff_ffff, 0, 32'hffff_ffff, 3}; v.known = 0;
    directed.push_back(v);
    v.r = '{1, 0, 4, 3, 0, 2, 3, 0}; v.known = 0;
    directed.push_back(v);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (directed[i]) begin
      if (directed[i].known && predict_crossing(directed[i].r) !== directed[i].want) begin
        $display("%0t: table row %0d expected %h actual %h", $time, i,
                 directed[i].want, predict_crossing(directed[i].r));
        error_count++;
      end
      send_request(directed[i].r);
    end

    // Random phases of idling and stalling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      repeat (N_RANDOM / 4) send_request(rand_request());
    end
    in_valid_i <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    while (crossing_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
design/ssi_pkg.sv
design/ssi_front.sv
design/ssi_numer.sv
design/ssi_div_stage.sv
design/segment_segment_intersection_unit.sv
sim/tb.sv
